/* rtl/core/scl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scl_pkg
// types, codes and the decimal parse step shared by the command line parser
// ----------------------------------------------------------------------------
package scl_pkg;

  // one received byte
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       receive_enable;
  } in_req_t;

  // one completed command
  typedef struct packed {
    logic [1:0]         command_kind;
    logic signed [31:0] first_value;
    logic signed [31:0] second_value;
    logic               brake_on;
    logic               auto_drive;
  } out_req_t;

  // message kinds, KindNone means no message open
  localparam logic [2:0] KindAngle = 3'd0;
  localparam logic [2:0] KindBrake = 3'd1;
  localparam logic [2:0] KindSpeed = 3'd2;
  localparam logic [2:0] KindDrive = 3'd3;
  localparam logic [2:0] KindNone  = 3'd4;

  // value parse phases
  localparam logic [1:0] PhBlanks = 2'd0;
  localparam logic [1:0] PhDigits = 2'd1;
  localparam logic [1:0] PhDone   = 2'd2;

  localparam logic [7:0] ChA     = 8'h41;
  localparam logic [7:0] ChB     = 8'h42;
  localparam logic [7:0] ChS     = 8'h53;
  localparam logic [7:0] ChD     = 8'h44;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;

  localparam logic [35:0] MagMax = 36'h0_7FFF_FFFF;

  // running state of one decimal value
  typedef struct packed {
    logic [1:0]  phase;
    logic        neg;
    logic [30:0] acc;
  } parse_t;

  // one byte of an atoi style parse, magnitude saturating at 2^31-1
  function automatic parse_t parse_step(input logic [7:0] c, input parse_t cur);
    parse_t      nxt;
    logic        digit;
    logic        blank;
    logic [35:0] prod;
    nxt   = cur;
    digit = (c >= 8'h30) && (c <= 8'h39);
    blank = (c == ChSpace) || ((c >= 8'h09) && (c <= 8'h0D));
    prod  = ({5'd0, cur.acc} << 3) + ({5'd0, cur.acc} << 1) + {32'd0, c[3:0]};
    case (cur.phase)
      PhBlanks: begin
        if (!blank) begin
          if (c == ChPlus) begin
            nxt.phase = PhDigits;
          end else if (c == ChMinus) begin
            nxt.neg   = 1'b1;
            nxt.phase = PhDigits;
          end else if (digit) begin
            nxt.acc   = {27'd0, c[3:0]};
            nxt.phase = PhDigits;
          end else begin
            nxt.phase = PhDone;
          end
        end
      end
      PhDigits: begin
        if (digit) begin
          nxt.acc = (prod > MagMax) ? MagMax[30:0] : prod[30:0];
        end else begin
          nxt.phase = PhDone;
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
    return nxt;
  endfunction

  // apply the sign to a saturated magnitude
  function automatic logic [31:0] signed_value(input parse_t p);
    logic [31:0] mag;
    mag = {1'b0, p.acc};
    return p.neg ? (32'd0 - mag) : mag;
  endfunction

endpackage

/* rtl/core/serial_command_line_parser_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_command_line_parser_top
// parses text commands A:angle,time B:brake S:speed D:drive ending in CR
// ----------------------------------------------------------------------------
// Takes one received byte per request and gives one command request for each
// line that ends in carriage return. A byte per cycle is sustained while the
// output register is free or draining: the byte is registered, then the parse
// logic (a times-ten add with saturation on each of the two values) updates
// the line state and loads the output register, so a carriage return passes
// through the input register before its command is loaded into the output
// register. While a finished command waits there and is not being drained,
// no byte is parsed, and the input register holds once a byte waits in it.
// Bytes with receive_enable low are dropped with no effect.
// A letter A, B, S or D, in that priority, or an open message picks the kind;
// any other byte outside a message clears the line. The first value starts at
// line position two, the second (angle time only) right after the first
// comma; missing values read as 0 and magnitudes saturate at 2^31-1. Bytes at
// positions LINE_LENGTH and beyond are not parsed. Brake and drive flags are
// held across commands and reported with every command.
module serial_command_line_parser_top #(
  parameter int LINE_LENGTH = 40
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  scl_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output scl_pkg::out_req_t out_req_o
);
  import scl_pkg::*;

  localparam int PosW = $clog2(LINE_LENGTH + 1);
  localparam logic [PosW-1:0] PosMax = PosW'(LINE_LENGTH);
  localparam logic [PosW-1:0] PosFirst = PosW'(2);

  // input register
  logic    in_valid_q, in_valid_d;
  in_req_t in_req_q;

  // line state
  logic [2:0]      kind_q, kind_d;
  logic [PosW-1:0] pos_q, pos_d;
  parse_t          first_q, first_d;
  parse_t          second_q, second_d;
  logic            comma_q, comma_d;
  logic            brake_q, brake_d;
  logic            drive_q, drive_d;

  // output register
  logic     out_valid_q, out_valid_d;
  out_req_t out_req_q, out_req_d;

  logic        proc_go;
  logic        out_load;
  logic [7:0]  c;
  logic [2:0]  pick;
  logic [31:0] v1;
  logic [31:0] v2;

  localparam parse_t ParseIdle = '{phase: PhBlanks, neg: 1'b0, acc: '0};

  // the parse stage may only run when the output slot is free or draining
  assign proc_go    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || proc_go;

  assign in_valid_d = (in_valid_i && in_ready_o) ? 1'b1 :
                      proc_go                    ? 1'b0 : in_valid_q;

  assign c = in_req_q.rx_byte;

  // kind selection by letter priority, open message counts as that letter
  always_comb begin
    if (c == ChA || kind_q == KindAngle) begin
      pick = KindAngle;
    end else if (c == ChB || kind_q == KindBrake) begin
      pick = KindBrake;
    end else if (c == ChS || kind_q == KindSpeed) begin
      pick = KindSpeed;
    end else if (c == ChD || kind_q == KindDrive) begin
      pick = KindDrive;
    end else begin
      pick = KindNone;
    end
  end

  always_comb begin
    kind_d    = kind_q;
    pos_d     = pos_q;
    first_d   = first_q;
    second_d  = second_q;
    comma_d   = comma_q;
    brake_d   = brake_q;
    drive_d   = drive_q;
    out_load  = 1'b0;
    v1        = '0;
    v2        = '0;
    out_req_d = out_req_q;

    if (proc_go && in_req_q.receive_enable) begin
      if (pick == KindNone) begin
        // stray byte: drop the line
        kind_d   = KindNone;
        pos_d    = '0;
        first_d  = ParseIdle;
        second_d = ParseIdle;
        comma_d  = 1'b0;
      end else begin
        kind_d = pick;
        if (pos_q < PosMax) begin
          if (pos_q >= PosFirst) begin
            first_d = parse_step(c, first_q);
          end
          if (comma_q) begin
            second_d = parse_step(c, second_q);
          end else if (c == ChComma) begin
            comma_d = 1'b1;
          end
          pos_d = pos_q + PosW'(1);
        end

        if (c == ChCr) begin
          v1 = signed_value(first_d);
          case (pick)
            KindAngle: v2 = signed_value(second_d);
            KindBrake: brake_d = (v1[7:0] != 8'd0);
            KindDrive: drive_d = (v1 != 32'd0);
            default:   v2 = '0;
          endcase
          out_load               = 1'b1;
          out_req_d.command_kind = pick[1:0];
          out_req_d.first_value  = v1;
          out_req_d.second_value = v2;
          out_req_d.brake_on     = brake_d;
          out_req_d.auto_drive   = drive_d;
          // line done, start fresh
          kind_d   = KindNone;
          pos_d    = '0;
          first_d  = ParseIdle;
          second_d = ParseIdle;
          comma_d  = 1'b0;
        end
      end
    end
  end

  assign out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      kind_q      <= KindNone;
      pos_q       <= '0;
      first_q     <= ParseIdle;
      second_q    <= ParseIdle;
      comma_q     <= 1'b0;
      brake_q     <= 1'b0;
      drive_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      kind_q      <= kind_d;
      pos_q       <= pos_d;
      first_q     <= first_d;
      second_q    <= second_d;
      comma_q     <= comma_d;
      brake_q     <= brake_d;
      drive_q     <= drive_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_req_q <= in_req_i;
    end
    if (out_load) begin
      out_req_q <= out_req_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

endmodule

/* rtl/core/scl_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scl_checker
// port level checks on the command line parser, bound to the top level
// ----------------------------------------------------------------------------
module scl_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input scl_pkg::out_req_t out_req_o
);
  import scl_pkg::*;

  // a stalled command holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_req_o))
    else $error("stalled command dropped or changed");

  // only angle commands carry a second value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.command_kind != KindAngle[1:0] |->
      out_req_o.second_value == 32'sd0)
    else $error("second value on non-angle command");

  // brake flag follows the brake command value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.command_kind == KindBrake[1:0] |->
      out_req_o.brake_on == (out_req_o.first_value[7:0] != 8'd0))
    else $error("brake flag mismatch");

  // drive flag follows the drive command value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.command_kind == KindDrive[1:0] |->
      out_req_o.auto_drive == (out_req_o.first_value != 32'sd0))
    else $error("drive flag mismatch");

  // saturated magnitude never reaches the most negative code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_req_o.first_value != 32'h8000_0000 &&
                    out_req_o.second_value != 32'h8000_0000)
    else $error("value beyond saturation");

endmodule

bind serial_command_line_parser_top scl_checker u_scl_checker (.*);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the serial command line parser
// ----------------------------------------------------------------------------
// Bytes go in one request at a time over valid/ready. A behavioral line
// parser in this file follows every accepted byte and queues the command that
// each carriage return should give. A monitor compares every command that
// leaves the block, field by field, with the oldest queued one. Directed
// tests cover each command kind and the parse corner cases. The random part
// sends mostly well-formed lines with random values, with noise bytes,
// dropped bytes and overlong lines mixed in. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import scl_pkg::*;

  localparam int LineLen = 40;
  localparam int HalfPeriod = 6;
  localparam int RandomBytes = 420;
  localparam int IdlePercent = 29;
  localparam int TailCycles = 20;

  // characters the bench needs beyond the package set
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  localparam logic [31:0] MagLimit = 32'h7FFF_FFFF;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  in_req_t  in_req_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  out_req_t out_req_o;

  serial_command_line_parser_top #(
    .LINE_LENGTH(LineLen)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_req_o  (out_req_o)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  // running state of one decimal field of the line
  typedef struct packed {
    logic [1:0]  phase;
    logic        neg;
    logic [31:0] mag;
  } number_state_t;

  // shadow of the line parser
  logic [2:0]    open_kind;
  int            line_pos;
  number_state_t first_num;
  number_state_t second_num;
  logic          after_comma;
  logic          brake_held;
  logic          drive_held;

  out_req_t      expected_cmds[$];
  logic [7:0]    line_bytes[$];
  int            mismatch_count = 0;
  int            enabled_sent = 0;
  bit            no_idle = 1'b0;

  // ---------------------------------------------------------------- predictor

  function automatic number_state_t atoi_advance(input logic [7:0] c,
                                                 input number_state_t cur);
    number_state_t nxt;
    logic          is_digit;
    logic          is_blank;
    logic [63:0]   grown;
    nxt      = cur;
    is_digit = (c >= ChZero) && (c <= ChNine);
    is_blank = (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
    grown    = {32'd0, cur.mag} * 64'd10 + {56'd0, c - ChZero};
    case (cur.phase)
      PhBlanks: begin
        if (!is_blank) begin
          if (c == ChPlus) begin
            nxt.phase = PhDigits;
          end else if (c == ChMinus) begin
            nxt.neg   = 1'b1;
            nxt.phase = PhDigits;
          end else if (is_digit) begin
            nxt.mag   = {24'd0, c - ChZero};
            nxt.phase = PhDigits;
          end else begin
            nxt.phase = PhDone;
          end
        end
      end
      PhDigits: begin
        if (is_digit) begin
          nxt.mag = (grown > {32'd0, MagLimit}) ? MagLimit : grown[31:0];
        end else begin
          nxt.phase = PhDone;
        end
      end
      default: begin
      end
    endcase
    return nxt;
  endfunction

  function automatic logic [31:0] number_value(input number_state_t n);
    return n.neg ? (32'd0 - n.mag) : n.mag;
  endfunction

  task automatic clear_line();
    open_kind   = KindNone;
    line_pos    = 0;
    first_num   = '{phase: PhBlanks, neg: 1'b0, mag: 32'd0};
    second_num  = '{phase: PhBlanks, neg: 1'b0, mag: 32'd0};
    after_comma = 1'b0;
  endtask

  // follow one accepted byte, queue a command when a line completes
  task automatic predict_command(input in_req_t req);
    logic [7:0]  c;
    logic [2:0]  kind;
    logic [31:0] v1;
    out_req_t    cmd;
    c = req.rx_byte;
    if (!req.receive_enable) return;
    if (c == ChA || open_kind == KindAngle) begin
      kind = KindAngle;
    end else if (c == ChB || open_kind == KindBrake) begin
      kind = KindBrake;
    end else if (c == ChS || open_kind == KindSpeed) begin
      kind = KindSpeed;
    end else if (c == ChD || open_kind == KindDrive) begin
      kind = KindDrive;
    end else begin
      clear_line();
      return;
    end
    open_kind = kind;
    // bytes past the line length are not stored
    if (line_pos < LineLen) begin
      if (line_pos >= 2) first_num = atoi_advance(c, first_num);
      if (after_comma) begin
        second_num = atoi_advance(c, second_num);
      end else if (c == ChComma) begin
        after_comma = 1'b1;
      end
      line_pos++;
    end
    if (c != ChCr) return;
    v1 = number_value(first_num);
    cmd.second_value = '0;
    if (kind == KindAngle) begin
      cmd.second_value = number_value(second_num);
    end else if (kind == KindBrake) begin
      brake_held = (v1[7:0] != 8'd0);
    end else if (kind == KindDrive) begin
      drive_held = (v1 != 32'd0);
    end
    cmd.command_kind = kind[1:0];
    cmd.first_value  = v1;
    cmd.brake_on     = brake_held;
    cmd.auto_drive   = drive_held;
    expected_cmds.push_back(cmd);
    clear_line();
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // sampled at the rising edge, before the block updates its outputs
  always @(posedge clk_i) begin
    out_req_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (expected_cmds.size() == 0) begin
        report_mismatch("command with no line pending");
      end else begin
        want = expected_cmds.pop_front();
        if (out_req_o.command_kind !== want.command_kind)
          report_mismatch($sformatf("command_kind got %0d want %0d",
                                    out_req_o.command_kind, want.command_kind));
        if (out_req_o.first_value !== want.first_value)
          report_mismatch($sformatf("first_value got %0d want %0d",
                                    out_req_o.first_value, want.first_value));
        if (out_req_o.second_value !== want.second_value)
          report_mismatch($sformatf("second_value got %0d want %0d",
                                    out_req_o.second_value, want.second_value));
        if (out_req_o.brake_on !== want.brake_on)
          report_mismatch($sformatf("brake_on got %b want %b",
                                    out_req_o.brake_on, want.brake_on));
        if (out_req_o.auto_drive !== want.auto_drive)
          report_mismatch($sformatf("auto_drive got %b want %b",
                                    out_req_o.auto_drive, want.auto_drive));
      end
    end
  end

  // receiver side: stall at random except in the no-idle stretch
  always @(negedge clk_i) begin
    out_ready_i <= no_idle || ($urandom_range(0, 99) >= IdlePercent);
  end

  // ---------------------------------------------------------------- sending

  // one request; valid stays high into the next request unless a gap is drawn
  task automatic send_byte(input logic [7:0] b, input logic en);
    in_req_t req;
    req.rx_byte        = b;
    req.receive_enable = en;
    if (!no_idle && $urandom_range(0, 99) < IdlePercent) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      // each further idle cycle drawn with the same odds
      while ($urandom_range(0, 99) < IdlePercent) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    predict_command(req);
    if (en) enabled_sent++;
  endtask

  task automatic send_text(input string s, input bit end_line);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b1);
    if (end_line) send_byte(ChCr, 1'b1);
  endtask

  // hold the input off until every queued command has come out
  task automatic drain_commands();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk_i);
  endtask

  // random decimal field: blanks, sign, digits; sometimes empty or overlong
  task automatic push_number();
    int pick;
    int digits;
    repeat (($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0)
      line_bytes.push_back($urandom_range(0, 1) ? ChSpace : ChTab);
    pick = $urandom_range(0, 5);
    if (pick == 0) line_bytes.push_back(ChPlus);
    if (pick == 1) line_bytes.push_back(ChMinus);
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      digits = 0;
    end else if (pick == 1) begin
      digits = $urandom_range(10, 12);
    end else if (pick == 2) begin
      digits = 1;
      line_bytes.push_back(ChZero);
      return;
    end else begin
      digits = $urandom_range(1, 6);
    end
    repeat (digits) line_bytes.push_back(ChZero + 8'($urandom_range(0, 9)));
  endtask

  // well-formed line with random content, now and then overlong
  task automatic push_random_line();
    logic [7:0] letter;
    int         kind;
    kind = $urandom_range(0, 3);
    letter = (kind == 0) ? ChA : (kind == 1) ? ChB : (kind == 2) ? ChS : ChD;
    line_bytes.push_back(letter);
    line_bytes.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                     : ChColon);
    push_number();
    if (kind == 0 ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 9) == 0)) begin
      line_bytes.push_back(ChComma);
      push_number();
    end
    if ($urandom_range(0, 24) == 0) begin
      while (line_bytes.size() < $urandom_range(LineLen - 2, LineLen + 15))
        line_bytes.push_back(ChSpace);
      line_bytes.push_back(ChComma);
      line_bytes.push_back(ChZero + 8'($urandom_range(1, 9)));
    end
    line_bytes.push_back(ChCr);
  endtask

  // send the built line; a dropped byte slips in now and then
  task automatic send_line_bytes();
    foreach (line_bytes[i]) begin
      if ($urandom_range(0, 19) == 0) send_byte(8'($urandom_range(0, 255)), 1'b0);
      send_byte(line_bytes[i], 1'b1);
    end
    line_bytes.delete();
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_each_command();
    send_text("A:-12,345", 1'b1);
    send_text("B:1", 1'b1);
    send_text("S:+7", 1'b1);
    send_text("D:5", 1'b1);
    send_text("D:0", 1'b1);
    // low byte of 256 is zero, so the brake releases
    send_text("B:256", 1'b1);
  endtask

  task automatic test_missing_values();
    send_text("S", 1'b1);
    send_text("A:5", 1'b1);
    send_text("B: -", 1'b1);
  endtask

  task automatic test_kind_switch();
    // a higher priority letter takes over the open line
    send_text("S:1B2", 1'b1);
    send_text("D:A3,4", 1'b1);
  endtask

  task automatic test_saturation();
    send_text("S:99999999999", 1'b1);
    send_text("A:-99999999999,2147483647", 1'b1);
  endtask

  task automatic test_long_line();
    string pad;
    pad = "A:1";
    while (pad.len() < LineLen + 4) pad = {pad, " "};
    // comma lands past the line length and must be ignored
    send_text({pad, ",5"}, 1'b1);
  endtask

  task automatic test_clearing_and_dropped_bytes();
    send_byte(ChCr, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_text("S:1", 1'b0);
    send_byte(ChA, 1'b0);
    send_byte(ChCr, 1'b0);
    send_text("2", 1'b1);
    send_text("S:", 1'b0);
    send_byte(8'hFF, 1'b1);
    send_text("5", 1'b1);
  endtask

  task automatic test_drain_pause();
    send_text("S:42", 1'b1);
    send_text("B:9", 1'b1);
    drain_commands();
    send_text("D:-1", 1'b1);
  endtask

  task automatic test_random_lines();
    int start_count;
    int iter;
    start_count = enabled_sent;
    iter = 0;
    while (enabled_sent - start_count < RandomBytes) begin
      // a run of lines with no idling on either side
      no_idle = (iter >= 15) && (iter < 35);
      if ($urandom_range(0, 99) < 85) begin
        push_random_line();
      end else begin
        // noise, which may also leave a broken line open
        repeat ($urandom_range(1, 4)) line_bytes.push_back(8'($urandom_range(0, 255)));
      end
      send_line_bytes();
      iter++;
    end
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    clear_line();
    brake_held = 1'b0;
    drive_held = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_each_command();
    test_missing_values();
    test_kind_switch();
    test_saturation();
    test_long_line();
    test_clearing_and_dropped_bytes();
    test_drain_pause();
    test_random_lines();

    drain_commands();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0 && expected_cmds.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #4_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/scl_pkg.sv
rtl/core/serial_command_line_parser_top.sv
rtl/core/scl_checker.sv
tb/tb_top.sv
